>>> rtl/mme_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by every module in the rtl folder; depends on nothing.
`default_nettype none

package mme_pkg;

  localparam int WORD_W        = 16;
  localparam int IDX_W         = 5;
  localparam int CFG_W         = 6;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int MAX_WORDS_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] MODE_BASE  = 2'd0;
  localparam logic [1:0] MODE_MOD   = 2'd1;
  localparam logic [1:0] MODE_EXP   = 2'd2;
  localparam logic [1:0] MODE_START = 2'd3;

  // Register index is taken from address bit 2.
  localparam logic REG_MOD_WORDS = 1'b0;
  localparam logic REG_EXP_WORDS = 1'b1;

  localparam logic [CFG_W-1:0] MOD_WORDS_RESET = 6'd32;
  localparam logic [CFG_W-1:0] EXP_WORDS_RESET = 6'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] operand_word;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [IDX_W-1:0]  result_index;
    logic              last;
    logic              error;
  } result_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD_BASE,
    CMD_LOAD_MOD,
    CMD_LOAD_EXP,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] operand_word;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] mod_words;
    logic [CFG_W-1:0] exp_words;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK,
    S_ERR,
    S_INIT,
    S_MM_START,
    S_BW_RD,
    S_BW_LD,
    S_PASS,
    S_PASS_DRAIN,
    S_PASS_SEL,
    S_COPY,
    S_COPY_DRAIN,
    S_EXP_RD,
    S_EXP_LD,
    S_NEXT_BIT,
    S_EMIT_RD,
    S_EMIT_LD
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/mme_front.sv
// Front end: classifies each accepted word into a command for the queue.
// Depends on mme_pkg.
`default_nettype none

module mme_front import mme_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  item_t item,
  input  logic  item_valid,
  output cmd_t  cmd,
  output logic  cmd_valid
);

  logic in_range;

  assign in_range  = int'(item.word_index) < MAX_WORDS;
  assign cmd_valid = item_valid;

  always_comb begin
    cmd.word_index   = item.word_index;
    cmd.operand_word = item.operand_word;
    unique case (item.mode)
      MODE_BASE:  cmd.kind = in_range ? CMD_LOAD_BASE : CMD_NOP;
      MODE_MOD:   cmd.kind = in_range ? CMD_LOAD_MOD : CMD_NOP;
      MODE_EXP:   cmd.kind = in_range ? CMD_LOAD_EXP : CMD_NOP;
      MODE_START: cmd.kind = CMD_START;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mme_queue.sv
// Short command queue between the front end and the engine.
// Depends on mme_pkg.
`default_nettype none

module mme_queue import mme_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = count == CW'(DEPTH);
  assign nonempty = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign dout     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mme_back.sv
// Engine: operand stores and the word-serial modular multiply sequencer.
// Depends on mme_pkg.
`default_nettype none

module mme_back import mme_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  cmd_t    cmd,
  input  logic    cmd_valid,
  output logic    cmd_pop,
  output result_t result,
  output logic    result_valid,
  input  logic    result_stall
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW = $clog2(MAX_WORDS + 1);

  back_state_t state, state_next;
  op_t         op;

  logic [LW-1:0] mlen;
  logic [LW-1:0] elen;
  logic [AW-1:0] mlast;
  logic [AW-1:0] elast;

  assign mlen  = (int'(cfg.mod_words) > MAX_WORDS) ? LW'(MAX_WORDS) : LW'(cfg.mod_words);
  assign elen  = (int'(cfg.exp_words) > MAX_WORDS) ? LW'(MAX_WORDS) : LW'(cfg.exp_words);
  assign mlast = AW'(mlen - LW'(1));
  assign elast = AW'(elen - LW'(1));

  logic [AW-1:0] cnt;
  logic [AW-1:0] bw;
  logic [AW-1:0] ew;
  logic [AW-1:0] oi;
  logic [AW-1:0] stg_i;
  logic [3:0]    bb;
  logic [3:0]    eb;
  logic          stg_v;
  logic          stg_copy;
  logic [15:0]   breg;
  logic [15:0]   ereg;
  logic [1:0]    cur;
  logic          rzero;
  logic          sh_c, ac, n2c, b1, b2;

  // Control strobes.
  logic issue_pass, issue_copy, load_write, init_write, err_load, emit_load;

  always_comb begin
    issue_pass = state == S_PASS;
    issue_copy = state == S_COPY;
    cmd_pop    = state == S_IDLE && cmd_valid;
    load_write = cmd_pop;
    init_write = state == S_INIT;
    err_load   = state == S_ERR && !result_valid;
    emit_load  = state == S_EMIT_LD;
  end

  // Memories: one write port and one registered read port each.
  logic [15:0] base_mem [MAX_WORDS];
  logic [15:0] mod_mem  [MAX_WORDS];
  logic [15:0] exp_mem  [MAX_WORDS];
  logic [15:0] acc_mem  [MAX_WORDS];
  logic [15:0] bred_mem [MAX_WORDS];

  logic [15:0] base_rd, mod_rd, exp_rd, acc_rd, bred_rd;
  logic [AW-1:0] mod_ra, acc_ra, ld_addr;
  logic [15:0] bank_rd [4];

  assign ld_addr = AW'(cmd.word_index);

  always_comb begin
    mod_ra = (state == S_CHK_RD) ? mlast : cnt;
    if (state == S_BW_RD) begin
      acc_ra = bw;
    end else if (state == S_EMIT_RD) begin
      acc_ra = oi;
    end else begin
      acc_ra = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_write && cmd.kind == CMD_LOAD_BASE) begin
      base_mem[ld_addr] <= cmd.operand_word;
    end
    base_rd <= base_mem[bw];
  end

  always_ff @(posedge clk) begin
    if (load_write && cmd.kind == CMD_LOAD_MOD) begin
      mod_mem[ld_addr] <= cmd.operand_word;
    end
    mod_rd <= mod_mem[mod_ra];
  end

  always_ff @(posedge clk) begin
    if (load_write && cmd.kind == CMD_LOAD_EXP) begin
      exp_mem[ld_addr] <= cmd.operand_word;
    end
    exp_rd <= exp_mem[ew];
  end

  always_ff @(posedge clk) begin
    if (init_write) begin
      acc_mem[cnt] <= (cnt == '0) ? 16'd1 : 16'd0;
    end else if (stg_v && stg_copy && op != OP_REDUCE) begin
      acc_mem[stg_i] <= bank_rd[cur];
    end
    acc_rd <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (stg_v && stg_copy && op == OP_REDUCE) begin
      bred_mem[stg_i] <= bank_rd[cur];
    end
    bred_rd <= bred_mem[bw];
  end

  // One word of the pass: t = 2r + bit*a, d1 = t - n, d2 = t - 2n.
  logic [15:0] rw, shl, av, n2;
  logic [16:0] s, x1, x2;
  logic [15:0] t;

  always_comb begin
    rw  = rzero ? 16'd0 : bank_rd[cur];
    shl = {rw[14:0], sh_c};
    if (!breg[bb]) begin
      av = 16'd0;
    end else if (op == OP_REDUCE) begin
      av = (stg_i == '0) ? 16'd1 : 16'd0;
    end else begin
      av = acc_rd;
    end
    s  = {1'b0, shl} + {1'b0, av} + {16'd0, ac};
    t  = s[15:0];
    n2 = {mod_rd[14:0], n2c};
    x1 = {1'b0, t} - {1'b0, mod_rd} - {16'd0, b1};
    x2 = {1'b0, t} - {1'b0, n2} - {16'd0, b2};
  end

  // Working banks rotate: cur holds r, the next three take t, d1 and d2.
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [15:0] mem [MAX_WORDS];
    logic [1:0]  role;
    logic [15:0] wdata;

    assign role = 2'(g) - cur;

    always_comb begin
      unique case (role)
        2'd1:    wdata = t;
        2'd2:    wdata = x1[15:0];
        default: wdata = x2[15:0];
      endcase
    end

    always_ff @(posedge clk) begin
      if (stg_v && !stg_copy && role != 2'd0) begin
        mem[stg_i] <= wdata;
      end
      bank_rd[g] <= mem[cnt];
    end
  end

  // Selection at the end of a pass, from the top carries and borrows.
  logic [1:0] t_top;
  logic       d1_ok, d2_ok;
  logic [1:0] cur_next;

  always_comb begin
    t_top = {1'b0, sh_c} + {1'b0, ac};
    d1_ok = (t_top != 2'd0) || !b1;
    d2_ok = t_top >= ({1'b0, n2c} + {1'b0, b2});
    priority if (d2_ok) begin
      cur_next = cur + 2'd3;
    end else if (d1_ok) begin
      cur_next = cur + 2'd2;
    end else begin
      cur_next = cur + 2'd1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (cmd_valid && cmd.kind == CMD_START) state_next = S_CHK_RD;
      S_CHK_RD:     state_next = S_CHK;
      S_CHK:        state_next = (mlen < LW'(2) || mod_rd == 16'd0) ? S_ERR : S_INIT;
      S_ERR:        if (!result_valid) state_next = S_IDLE;
      S_INIT:       if (cnt == mlast) state_next = S_MM_START;
      S_MM_START:   state_next = S_BW_RD;
      S_BW_RD:      state_next = S_BW_LD;
      S_BW_LD:      state_next = S_PASS;
      S_PASS:       if (cnt == mlast) state_next = S_PASS_DRAIN;
      S_PASS_DRAIN: state_next = S_PASS_SEL;
      S_PASS_SEL: begin
        if (bb != 4'd0) begin
          state_next = S_PASS;
        end else begin
          state_next = (bw == '0) ? S_COPY : S_BW_RD;
        end
      end
      S_COPY:       if (cnt == mlast) state_next = S_COPY_DRAIN;
      S_COPY_DRAIN: begin
        unique case (op)
          OP_REDUCE: state_next = (elen == '0) ? S_EMIT_RD : S_EXP_RD;
          OP_SQUARE: state_next = ereg[eb] ? S_MM_START : S_NEXT_BIT;
          default:   state_next = S_NEXT_BIT;
        endcase
      end
      S_EXP_RD:     state_next = S_EXP_LD;
      S_EXP_LD:     state_next = S_MM_START;
      S_NEXT_BIT: begin
        if (eb != 4'd0) begin
          state_next = S_MM_START;
        end else begin
          state_next = (ew == '0) ? S_EMIT_RD : S_EXP_RD;
        end
      end
      S_EMIT_RD:    if (!result_valid) state_next = S_EMIT_LD;
      S_EMIT_LD:    state_next = (oi == mlast) ? S_IDLE : S_EMIT_RD;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stg_v        <= 1'b0;
      result_valid <= 1'b0;
      cur          <= 2'd0;
    end else begin
      state <= state_next;
      stg_v <= issue_pass || issue_copy;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (err_load || emit_load) begin
        result_valid <= 1'b1;
      end
      if (state == S_PASS_SEL) begin
        cur <= cur_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_i    <= cnt;
    stg_copy <= issue_copy;

    if (state == S_INIT || state == S_PASS || state == S_COPY) begin
      cnt <= (cnt == mlast) ? '0 : cnt + AW'(1);
    end else begin
      cnt <= '0;
    end

    if (stg_v && !stg_copy) begin
      sh_c <= rw[15];
      ac   <= s[16];
      n2c  <= mod_rd[15];
      b1   <= x1[16];
      b2   <= x2[16];
    end

    unique case (state)
      S_IDLE: oi <= '0;
      S_CHK:  op <= OP_REDUCE;
      S_MM_START: begin
        bw    <= mlast;
        bb    <= 4'd15;
        rzero <= 1'b1;
        sh_c  <= 1'b0;
        ac    <= 1'b0;
        n2c   <= 1'b0;
        b1    <= 1'b0;
        b2    <= 1'b0;
      end
      S_BW_LD: begin
        unique case (op)
          OP_REDUCE: breg <= base_rd;
          OP_SQUARE: breg <= acc_rd;
          default:   breg <= bred_rd;
        endcase
      end
      S_PASS_SEL: begin
        rzero <= 1'b0;
        sh_c  <= 1'b0;
        ac    <= 1'b0;
        n2c   <= 1'b0;
        b1    <= 1'b0;
        b2    <= 1'b0;
        if (bb == 4'd0) begin
          bb <= 4'd15;
          bw <= bw - AW'(1);
        end else begin
          bb <= bb - 4'd1;
        end
      end
      S_COPY_DRAIN: begin
        if (op == OP_REDUCE) begin
          ew <= elast;
          eb <= 4'd15;
        end else if (op == OP_SQUARE && ereg[eb]) begin
          op <= OP_MULT;
        end
      end
      S_EXP_LD: begin
        ereg <= exp_rd;
        op   <= OP_SQUARE;
      end
      S_NEXT_BIT: begin
        op <= OP_SQUARE;
        if (eb == 4'd0) begin
          eb <= 4'd15;
          ew <= ew - AW'(1);
        end else begin
          eb <= eb - 4'd1;
        end
      end
      S_EMIT_LD: oi <= oi + AW'(1);
      default: ;
    endcase

    if (err_load) begin
      result.result_word  <= '0;
      result.result_index <= '0;
      result.last         <= 1'b1;
      result.error        <= 1'b1;
    end else if (emit_load) begin
      result.result_word  <= acc_rd;
      result.result_index <= IDX_W'(oi);
      result.last         <= oi == mlast;
      result.error        <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/multiprecision_modular_exponentiation_top.sv
// Top level of the modular exponentiation block: register port, front end,
// command queue and engine. Depends on mme_pkg, mme_front, mme_queue, mme_back.
`default_nettype none

// Computes base^exponent mod modulus over 16-bit words, least significant
// word first. Load words (one per cycle while the queue is not full) write
// one word of the base, the modulus or the exponent; they pass through a
// four-entry queue and give no result. A start word runs left-to-right
// square-and-multiply and then emits modulus_words result words, the last
// one marked; a modulus shorter than two words or with a zero top word
// gives a single error word instead. Each modular multiply is an interleaved
// shift-and-add over the bits of the second operand: every bit is one
// word-serial pass through the working banks that forms 2r+a, 2r+a-n and
// 2r+a-2n together and keeps the reduced one. The first multiply of a run
// reduces the base. The engine handles one start at a time; the queue keeps
// accepting words meanwhile until it fills. Registers modulus_words
// (address 0) and exponent_words (address 4) are taken as MAX_WORDS when
// larger; the user must write them only while idle, and the block itself
// does not enforce this.

module multiprecision_modular_exponentiation_top import mme_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic              item_valid,
  output logic              item_stall,
  output result_t           result,
  output logic              result_valid,
  input  logic              result_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t front_cmd;
  logic front_valid;
  cmd_t queue_cmd;
  logic queue_nonempty;
  logic queue_pop;
  logic queue_full;
  logic cfg_write;

  // Configuration registers; the register is selected by address bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mod_words <= MOD_WORDS_RESET;
      cfg.exp_words <= EXP_WORDS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MOD_WORDS) begin
        cfg.mod_words <= pwdata[CFG_W-1:0];
      end else begin
        cfg.exp_words <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_EXP_WORDS) begin
      prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.exp_words};
    end else begin
      prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.mod_words};
    end
  end

  // The input stalls only when the queue is full.
  assign item_stall = queue_full;

  mme_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .item       (item),
    .item_valid (item_valid),
    .cmd        (front_cmd),
    .cmd_valid  (front_valid)
  );

  mme_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .din      (front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .dout     (queue_cmd),
    .nonempty (queue_nonempty)
  );

  mme_back #(.MAX_WORDS(MAX_WORDS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (queue_cmd),
    .cmd_valid    (queue_nonempty),
    .cmd_pop      (queue_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef SYNTH
  // An error word stands alone: it is the last word, at index zero, holding zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error |->
      result.last && result.result_index == '0 && result.result_word == '0)
    else $error("error word is not a lone zero word");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result offered right after reset");

  // The queue never reports full while it is empty.
  assert property (@(posedge clk) disable iff (rst)
    queue_full |-> queue_nonempty)
    else $error("queue full while empty");
`endif

endmodule

`default_nettype wire

>>> sim/multiprecision_modular_exponentiation_top_tb.sv
// Testbench for the modular exponentiation block: loads words, starts runs,
// checks every result word against a wide-integer prediction of base^exp mod n.
// Depends on mme_pkg and the block's RTL only.
`timescale 1ns / 1ps

// Keeps a copy of the operand stores and register settings, predicts the
// result words of every start, and compares the words the block emits.
class modexp_scoreboard;
  bit [15:0] base_mem [32];
  bit [15:0] mod_mem [32];
  bit [15:0] exp_mem [32];
  int unsigned mod_words_cfg;
  int unsigned exp_words_cfg;
  mme_pkg::result_t pending_words[$];
  int unsigned mismatches;
  int unsigned starts;
  int unsigned error_runs;
  int unsigned words_checked;

  function void set_reg(bit idx, int unsigned value);
    if (idx == mme_pkg::REG_MOD_WORDS) mod_words_cfg = value & 6'h3F;
    else exp_words_cfg = value & 6'h3F;
  endfunction

  // Called for every input word that the block accepts.
  function void note_item(mme_pkg::item_t it);
    int unsigned m;
    int unsigned e;
    logic [1023:0] n;
    logic [1023:0] b;
    logic [1023:0] acc;
    mme_pkg::result_t r;
    case (it.mode)
      mme_pkg::MODE_BASE: base_mem[it.word_index] = it.operand_word;
      mme_pkg::MODE_MOD:  mod_mem[it.word_index] = it.operand_word;
      mme_pkg::MODE_EXP:  exp_mem[it.word_index] = it.operand_word;
      default: begin
        starts++;
        m = (mod_words_cfg > 32) ? 32 : mod_words_cfg;
        e = (exp_words_cfg > 32) ? 32 : exp_words_cfg;
        if (m < 2 || mod_mem[m-1] == 16'h0000) begin
          // A short modulus or a zero top word gives a single error word.
          error_runs++;
          r = '0;
          r.last = 1'b1;
          r.error = 1'b1;
          pending_words.push_back(r);
        end else begin
          n = '0;
          b = '0;
          for (int i = 0; i < m; i++) begin
            n[i*16 +: 16] = mod_mem[i];
            b[i*16 +: 16] = base_mem[i];
          end
          acc = 1;
          for (int k = int'(e) * 16 - 1; k >= 0; k--) begin
            acc = (acc * acc) % n;
            if (exp_mem[k/16][k%16]) acc = (acc * b) % n;
          end
          // Without any exponent bit the loop never reduces; n exceeds 1 anyway.
          for (int i = 0; i < m; i++) begin
            r.result_word = acc[i*16 +: 16];
            r.result_index = i[4:0];
            r.last = (i == m - 1);
            r.error = 1'b0;
            pending_words.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function void check_word(mme_pkg::result_t got);
    mme_pkg::result_t want;
    words_checked++;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = pending_words.pop_front();
    if (got.result_word !== want.result_word || got.result_index !== want.result_index ||
        got.last !== want.last || got.error !== want.error) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected word %h idx %0d last %b err %b, got %h idx %0d last %b err %b",
                 want.result_word, want.result_index, want.last, want.error,
                 got.result_word, got.result_index, got.last, got.error);
    end
  endfunction
endclass

module multiprecision_modular_exponentiation_top_tb;
  import mme_pkg::*;

  logic clk;
  logic rst;
  item_t item;
  logic item_valid;
  logic item_stall;
  result_t result;
  logic result_valid;
  logic result_stall;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  modexp_scoreboard sb;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  int unsigned items_sent;

  // No accepted word, in or out, for this many cycles means the block has hung. The
  // slowest run that this bench starts, a 32-word modulus with a one-word exponent,
  // stays well inside this limit.
  localparam int unsigned WATCHDOG_LIMIT = 1500000;

  multiprecision_modular_exponentiation_top dut (
    .clk(clk), .rst(rst),
    .item(item), .item_valid(item_valid), .item_stall(item_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side samples at the edge and then draws its stall for the
  // next cycle, so acceptance is judged on the values held before the edge.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        sb.check_word(result);
        quiet_cycles = 0;
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", sb.pending_words.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Setup cycle then access cycle; pready is always high, so the register
  // takes the value at the edge that ends the access cycle.
  task automatic write_reg(input bit idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Presents one word, with a random sender gap first, and holds it until
  // the block takes it. Called right after waiting on posedge clk.
  task automatic send_word(input logic [1:0] mode, input int unsigned idx,
                           input logic [15:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= '{mode: mode, word_index: idx[4:0], operand_word: data};
    item_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    sb.note_item(item);
    quiet_cycles = 0;
    items_sent++;
  endtask

  // Lets every expected word arrive, then gives the queue time to drain any
  // loads still in flight, so a register write finds the block idle.
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_sizes(input int unsigned mw, input int unsigned ew);
    settle();
    write_reg(REG_MOD_WORDS, mw);
    write_reg(REG_EXP_WORDS, ew);
  endtask

  task automatic set_idling(input int unsigned sel);
    case (sel % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 49; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 49; end
      default: begin send_gap_pct = 27; stall_pct = 27; end
    endcase
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly loads of random words at any index, with a start about one word
  // in eight; each start sees whatever the stores hold at that moment.
  task automatic random_burst(input int unsigned count);
    logic [1:0] mode;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) mode = MODE_START;
      else mode = 2'($urandom_range(2));
      send_word(mode, $urandom_range(31), pick_word());
    end
  endtask

  initial begin
    sb = new();
    sb.set_reg(REG_MOD_WORDS, MOD_WORDS_RESET);
    sb.set_reg(REG_EXP_WORDS, EXP_WORDS_RESET);
    rst = 1'b1;
    item = '0;
    item_valid = 1'b0;
    result_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_cycles = 0;
    items_sent = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every store first so that no start ever reads an unwritten word.
    set_sizes(2, 1);
    for (int i = 0; i < 32; i++) begin
      send_word(MODE_BASE, i, pick_word());
      send_word(MODE_MOD, i, pick_word());
      send_word(MODE_EXP, i, pick_word());
    end

    // Directed: largest two-word modulus with a base equal to it.
    send_word(MODE_MOD, 0, 16'hFFFF);
    send_word(MODE_MOD, 1, 16'hFFFF);
    send_word(MODE_BASE, 0, 16'hFFFF);
    send_word(MODE_BASE, 1, 16'hFFFF);
    send_word(MODE_EXP, 0, 16'hFFFF);
    send_word(MODE_START, 0, 16'h0000);
    // Base above the modulus, smallest valid top word.
    send_word(MODE_MOD, 1, 16'h0001);
    send_word(MODE_MOD, 0, 16'h0000);
    send_word(MODE_BASE, 0, 16'h1234);
    send_word(MODE_EXP, 0, 16'h8001);
    send_word(MODE_START, 31, 16'hFFFF);
    // All-zero exponent gives one.
    send_word(MODE_EXP, 0, 16'h0000);
    send_word(MODE_START, 0, 16'h0000);
    // Zero top modulus word gives the error word.
    send_word(MODE_MOD, 1, 16'h0000);
    send_word(MODE_START, 0, 16'h0000);
    send_word(MODE_MOD, 1, 16'h8000);

    // Zero exponent length acts as a zero exponent.
    set_sizes(3, 0);
    send_word(MODE_MOD, 2, 16'hC001);
    send_word(MODE_START, 0, 16'h0000);
    // Modulus lengths of zero and one are rejected.
    set_sizes(0, 1);
    send_word(MODE_START, 0, 16'h0000);
    set_sizes(1, 1);
    send_word(MODE_START, 0, 16'h0000);
    // Oversized length saturates to 32 words; a zero top word keeps it cheap.
    set_sizes(63, 2);
    send_word(MODE_MOD, 31, 16'h0000);
    send_word(MODE_START, 0, 16'h0000);
    // One full-width run with a sparse one-word exponent.
    set_sizes(32, 1);
    send_word(MODE_MOD, 31, 16'h0F0F);
    send_word(MODE_EXP, 0, 16'h8001);
    send_word(MODE_START, 0, 16'h0000);
    // Longest exponent, saturated from 63, on a small modulus.
    set_sizes(2, 63);
    send_word(MODE_MOD, 1, 16'hA5A5);
    send_word(MODE_START, 0, 16'h0000);

    // Random phases on small sizes, cycling through four idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_sizes($urandom_range(2, 4), $urandom_range(1, 2));
      set_idling(ph);
      random_burst(30);
    end

    settle();
    $display("ran %0d words: %0d starts (%0d rejected), %0d result words checked",
             items_sent, sb.starts, sb.error_runs, sb.words_checked);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.mismatches,
               sb.pending_words.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/mme_pkg.sv
rtl/mme_front.sv
rtl/mme_queue.sv
rtl/mme_back.sv
rtl/multiprecision_modular_exponentiation_top.sv
sim/multiprecision_modular_exponentiation_top_tb.sv
